// File: sv/rvmeu_pkg.sv
// ----------------------------------------------------------------------------
// rvmeu_pkg: shared types and constants of the register vm execute unit
// Command codes, sizes and sequencer states.
// ----------------------------------------------------------------------------
package rvmeu_pkg;

  localparam int unsigned RegCount = 16;
  localparam int unsigned RegIdxW  = $clog2(RegCount);
  localparam int unsigned MemWords = 1024;
  localparam int unsigned MemAddrW = $clog2(MemWords);
  localparam int unsigned DataW    = 32;

  typedef enum logic [4:0] {
    CmdHalt  = 5'd0,
    CmdLoadi = 5'd1,
    CmdAdd   = 5'd2,
    CmdPush  = 5'd3,
    CmdPop   = 5'd4,
    CmdCmp   = 5'd5,
    CmdJmpeq = 5'd6,
    CmdSub   = 5'd7,
    CmdMemr  = 5'd8,
    CmdMemw  = 5'd9,
    CmdJmp   = 5'd10,
    CmdNop   = 5'd11,
    CmdMul   = 5'd12,
    CmdDiv   = 5'd13,
    CmdLoada = 5'd14,
    CmdLoadb = 5'd15,
    CmdPushl = 5'd16,
    CmdSinc  = 5'd17,
    CmdSdec  = 5'd18,
    CmdRcur  = 5'd19,
    CmdWcur  = 5'd20
  } cmd_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StRead,
    StExec,
    StDiv,
    StMem,
    StOut
  } state_e;

  typedef struct packed {
    logic              jump_taken;
    logic [DataW-1:0]  jump_target;
    logic              halted;
    logic              compare_flag;
    logic [9:0]        stack_pointer;
    logic              write_valid;
    logic [DataW-1:0]  written_value;
  } result_t;

endpackage

// File: sv/register_vm_execute_unit.sv
// ----------------------------------------------------------------------------
// register_vm_execute_unit: instruction execute stage of a small register vm
// Register file, data memory, stack pointer, compare flag, shared alu.
// ----------------------------------------------------------------------------
// After reset the unit clears the data memory, one word a cycle, before it
// takes its first instruction. An instruction is taken in an idle cycle and
// then passes through operand read, execute, memory access and result beat;
// the unit takes no new instruction until its result beat is taken. Divide
// adds a wait on the one-bit-a-cycle divider, and a stalled result beat holds
// the unit until it is taken. The stack_top write is taken at any time and
// reloads the stack pointer.
module register_vm_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[4:0], dest_reg[8:5], src_a[12:9], src_b[16:13], immediate[48:17]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // jump_taken[0], jump_target[32:1], halted[33], compare_flag[34],
  // stack_pointer[44:35], write_valid[45], written_value[77:46]
  output logic [79:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_data_i
);

  localparam int unsigned AW = rvmeu_pkg::MemAddrW;
  localparam int unsigned RW = rvmeu_pkg::RegIdxW;

  rvmeu_pkg::state_e state_q, state_d;

  logic [31:0]    regs_q [rvmeu_pkg::RegCount];
  logic [AW-1:0]  sp_q, sp_d;
  logic           flag_q, flag_d, stop_q, stop_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [4:0]     cmd_q;
  logic [RW-1:0]  d_q, a_q, b_q;
  logic [31:0]    imm_q, opd_q, opa_q, opb_q;
  rvmeu_pkg::result_t res_q, res_d;

  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [31:0]    ram_wdata, ram_rdata;
  logic           div_start, div_done;
  logic [31:0]    div_quo;
  logic [31:0]    alu_res;
  logic           in_beat;

  assign in_beat      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == rvmeu_pkg::StIdle);
  assign cfg_ready_o  = 1'b1;
  assign m_axis_tvalid = (state_q == rvmeu_pkg::StOut);
  assign m_axis_tdata = {2'b00, res_q.written_value, res_q.write_valid, res_q.stack_pointer,
                         res_q.compare_flag, res_q.halted, res_q.jump_target,
                         res_q.jump_taken};

  rvmeu_ram #(.Width(32), .Depth(rvmeu_pkg::MemWords)) u_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  rvmeu_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (regs_q[a_q]),
    .divisor_i  (regs_q[b_q]),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // shared alu
  always_comb begin
    case (rvmeu_pkg::cmd_e'(cmd_q))
      rvmeu_pkg::CmdSub: alu_res = opa_q - opb_q;
      rvmeu_pkg::CmdMul: alu_res = opa_q * opb_q;
      default:           alu_res = opa_q + opb_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rvmeu_pkg::StClear: if (clr_q == AW'(rvmeu_pkg::MemWords - 1)) state_d = rvmeu_pkg::StIdle;
      rvmeu_pkg::StIdle:  if (in_beat) state_d = rvmeu_pkg::StRead;
      rvmeu_pkg::StRead: begin
        if (!stop_q && cmd_q == rvmeu_pkg::CmdDiv) state_d = rvmeu_pkg::StDiv;
        else state_d = rvmeu_pkg::StExec;
      end
      rvmeu_pkg::StDiv:   if (div_done) state_d = rvmeu_pkg::StExec;
      rvmeu_pkg::StExec:  state_d = rvmeu_pkg::StMem;
      rvmeu_pkg::StMem:   state_d = rvmeu_pkg::StOut;
      rvmeu_pkg::StOut:   if (m_axis_tready) state_d = rvmeu_pkg::StIdle;
      default:            state_d = rvmeu_pkg::StIdle;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = sp_q;
    ram_wdata = '0;
    div_start = 1'b0;
    clr_d     = clr_q;
    sp_d      = sp_q;
    flag_d    = flag_q;
    stop_d    = stop_q;
    res_d     = res_q;
    unique case (state_q)
      rvmeu_pkg::StClear: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + AW'(1);
      end
      rvmeu_pkg::StRead: begin
        div_start = !stop_q && (cmd_q == rvmeu_pkg::CmdDiv);
        res_d     = '0;
        if (!stop_q) begin
          case (rvmeu_pkg::cmd_e'(cmd_q))
            rvmeu_pkg::CmdPush, rvmeu_pkg::CmdPushl: sp_d = sp_q - AW'(1);
            default: ;
          endcase
        end
      end
      rvmeu_pkg::StExec: begin
        if (!stop_q) begin
          case (rvmeu_pkg::cmd_e'(cmd_q))
            rvmeu_pkg::CmdHalt: stop_d = 1'b1;
            rvmeu_pkg::CmdLoadi: begin
              res_d.write_valid = 1'b1; res_d.written_value = imm_q;
            end
            rvmeu_pkg::CmdAdd, rvmeu_pkg::CmdSub, rvmeu_pkg::CmdMul: begin
              res_d.write_valid = 1'b1; res_d.written_value = alu_res;
            end
            rvmeu_pkg::CmdDiv: begin
              res_d.write_valid = 1'b1; res_d.written_value = div_quo;
            end
            rvmeu_pkg::CmdCmp: flag_d = (opd_q == opa_q);
            rvmeu_pkg::CmdJmp: begin
              res_d.jump_taken = 1'b1; res_d.jump_target = imm_q;
            end
            rvmeu_pkg::CmdJmpeq: begin
              res_d.jump_taken  = flag_q;
              res_d.jump_target = flag_q ? imm_q : '0;
            end
            rvmeu_pkg::CmdLoada: begin
              res_d.write_valid = 1'b1; res_d.written_value = {opd_q[31:16], imm_q[15:0]};
            end
            rvmeu_pkg::CmdLoadb: begin
              res_d.write_valid = 1'b1; res_d.written_value = {imm_q[15:0], opd_q[15:0]};
            end
            rvmeu_pkg::CmdPush: begin
              ram_we = 1'b1; ram_wdata = opd_q;
            end
            rvmeu_pkg::CmdPushl: begin
              ram_we = 1'b1; ram_wdata = {16'h0000, imm_q[15:0]};
            end
            rvmeu_pkg::CmdWcur: begin
              ram_we = 1'b1; ram_wdata = opd_q;
            end
            rvmeu_pkg::CmdMemw: begin
              ram_we = 1'b1; ram_addr = opa_q[AW-1:0]; ram_wdata = opd_q;
            end
            rvmeu_pkg::CmdMemr: ram_addr = opa_q[AW-1:0];
            rvmeu_pkg::CmdSinc: sp_d = sp_q - imm_q[AW-1:0];
            rvmeu_pkg::CmdSdec: sp_d = sp_q + imm_q[AW-1:0];
            default: ;
          endcase
        end
      end
      rvmeu_pkg::StMem: begin
        if (!stop_q) begin
          case (rvmeu_pkg::cmd_e'(cmd_q))
            rvmeu_pkg::CmdPop: begin
              res_d.write_valid = 1'b1; res_d.written_value = ram_rdata;
              ram_we = 1'b1;
              sp_d   = sp_q + AW'(1);
            end
            rvmeu_pkg::CmdRcur, rvmeu_pkg::CmdMemr: begin
              res_d.write_valid = 1'b1; res_d.written_value = ram_rdata;
            end
            default: ;
          endcase
        end
        res_d.halted        = stop_d;
        res_d.compare_flag  = flag_q;
        res_d.stack_pointer = 10'(sp_d);
      end
      default: ;
    endcase
    if (cfg_valid_i) begin
      sp_d = AW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rvmeu_pkg::StClear;
      clr_q   <= '0;
      sp_q    <= '0;
      flag_q  <= 1'b0;
      stop_q  <= 1'b0;
      for (int i = 0; i < int'(rvmeu_pkg::RegCount); i++) regs_q[i] <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sp_q    <= sp_d;
      flag_q  <= flag_d;
      stop_q  <= stop_d;
      if (state_q == rvmeu_pkg::StMem && res_d.write_valid) begin
        regs_q[d_q] <= res_d.written_value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_beat) begin
      cmd_q <= s_axis_tdata[4:0];
      d_q   <= s_axis_tdata[5 +: RW];
      a_q   <= s_axis_tdata[9 +: RW];
      b_q   <= s_axis_tdata[13 +: RW];
      imm_q <= s_axis_tdata[48:17];
    end
    if (state_q == rvmeu_pkg::StIdle) begin
      opd_q <= '0;
    end else if (state_q == rvmeu_pkg::StRead) begin
      opd_q <= regs_q[d_q];
      opa_q <= regs_q[a_q];
      opb_q <= regs_q[b_q];
    end
  end

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready)
    else $error("input taken while busy");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q)
    else $error("halt cleared without reset");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(res_q))
    else $error("result changed while stalled");

endmodule

// File: sv/rvmeu_ram.sv
// ----------------------------------------------------------------------------
// rvmeu_ram: generic single port ram
// One write and one read of the same address per cycle, registered read data.
// ----------------------------------------------------------------------------
module rvmeu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: sv/rvmeu_divider.sv
// ----------------------------------------------------------------------------
// rvmeu_divider: signed 32-bit radix-2 divider
// One quotient bit per cycle, truncating, divide by zero gives zero.
// ----------------------------------------------------------------------------
module rvmeu_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d, zero_q, zero_d;
  logic [32:0] trial;
  logic [31:0] shifted_rem;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    shifted_rem = {rem_q[30:0], quo_q[31]};
    trial = {1'b0, shifted_rem} - {1'b0, dvs_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i[31] ? (~dividend_i + 32'd1) : dividend_i;
      dvs_d  = divisor_i[31] ? (~divisor_i + 32'd1) : divisor_i;
      neg_d  = dividend_i[31] ^ divisor_i[31];
      zero_d = (divisor_i == '0);
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted_rem;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  assign done_o     = busy_q && (cnt_q == 6'd1);
  assign quotient_o = zero_q ? '0 : (neg_q ? (~quo_d + 32'd1) : quo_d);

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: register vm execute unit
// Streams decoded instructions through the unit and checks every result beat
// against an in-bench model of the register file, data memory, stack pointer
// and compare flag. Several stack_top settings are exercised between phases.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [31:0] imm;
    logic [3:0]  rb;
    logic [3:0]  ra;
    logic [3:0]  rd;
    logic [4:0]  cmd;
  } instr_t;

  typedef struct packed {
    logic        wv;
    logic [31:0] wval;
    logic        jump;
    logic [31:0] target;
    logic        halted;
    logic        flag;
    logic [9:0]  sp;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [9:0]  cfg_data_i = '0;

  register_vm_execute_unit DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [31:0] vm_regs [16];
  logic [31:0] vm_mem [1024];
  logic [9:0]  vm_sp;
  logic        vm_flag;
  logic        vm_stopped;

  instr_t   pending_instrs [$];
  outcome_t expected_results [$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       mismatches = 0;
  int       in_beats = 0;
  int       in_beats_seen = 0;

  function automatic outcome_t execute_instr(instr_t ins);
    outcome_t o;
    logic [31:0] va, vb, vd;
    logic [9:0]  addr;
    logic signed [31:0] sa, sb;
    o = '0;
    va = vm_regs[ins.ra];
    vb = vm_regs[ins.rb];
    vd = vm_regs[ins.rd];
    if (!vm_stopped) begin
      case (ins.cmd)
        rvmeu_pkg::CmdHalt:  vm_stopped = 1'b1;
        rvmeu_pkg::CmdLoadi: begin o.wv = 1; o.wval = ins.imm; end
        rvmeu_pkg::CmdAdd:   begin o.wv = 1; o.wval = va + vb; end
        rvmeu_pkg::CmdSub:   begin o.wv = 1; o.wval = va - vb; end
        rvmeu_pkg::CmdMul:   begin o.wv = 1; o.wval = va * vb; end
        rvmeu_pkg::CmdDiv: begin
          sa = va;
          sb = vb;
          o.wv = 1;
          if (sb == 0) o.wval = 0;
          else if (sa == 32'sh80000000 && sb == -1) o.wval = va;
          else o.wval = sa / sb;
        end
        rvmeu_pkg::CmdPush:  begin vm_sp = vm_sp - 1; vm_mem[vm_sp] = vd; end
        rvmeu_pkg::CmdPushl: begin
          vm_sp = vm_sp - 1; vm_mem[vm_sp] = {16'h0, ins.imm[15:0]};
        end
        rvmeu_pkg::CmdPop: begin
          o.wv = 1;
          o.wval = vm_mem[vm_sp];
          vm_mem[vm_sp] = 0;
          vm_sp = vm_sp + 1;
        end
        rvmeu_pkg::CmdCmp:   vm_flag = (vd == va);
        rvmeu_pkg::CmdJmpeq: if (vm_flag) begin o.jump = 1; o.target = ins.imm; end
        rvmeu_pkg::CmdJmp:   begin o.jump = 1; o.target = ins.imm; end
        rvmeu_pkg::CmdMemr:  begin addr = va[9:0]; o.wv = 1; o.wval = vm_mem[addr]; end
        rvmeu_pkg::CmdMemw:  begin addr = va[9:0]; vm_mem[addr] = vd; end
        rvmeu_pkg::CmdLoada: begin o.wv = 1; o.wval = {vd[31:16], ins.imm[15:0]}; end
        rvmeu_pkg::CmdLoadb: begin o.wv = 1; o.wval = {ins.imm[15:0], vd[15:0]}; end
        rvmeu_pkg::CmdSinc:  vm_sp = vm_sp - ins.imm[9:0];
        rvmeu_pkg::CmdSdec:  vm_sp = vm_sp + ins.imm[9:0];
        rvmeu_pkg::CmdRcur:  begin o.wv = 1; o.wval = vm_mem[vm_sp]; end
        rvmeu_pkg::CmdWcur:  vm_mem[vm_sp] = vd;
        default: ;
      endcase
      if (o.wv) vm_regs[ins.rd] = o.wval;
    end
    o.halted = vm_stopped;
    o.flag = vm_flag;
    o.sp = vm_sp;
    return o;
  endfunction

  // input beat capture
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(execute_instr(instr_t'(s_axis_tdata[48:0])));
      void'(pending_instrs.pop_front());
      in_beats++;
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_beats != in_beats_seen) begin
        in_beats_seen = in_beats;
        if (pending_instrs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {7'b0, pending_instrs[0]};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    outcome_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.jump = m_axis_tdata[0];
      got.target = m_axis_tdata[32:1];
      got.halted = m_axis_tdata[33];
      got.flag = m_axis_tdata[34];
      got.sp = m_axis_tdata[44:35];
      got.wv = m_axis_tdata[45];
      got.wval = m_axis_tdata[77:46];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected jump %0d tgt %h halt %0d flag %0d sp %0d wv %0d",
                      " val %h, got jump %0d tgt %h halt %0d flag %0d sp %0d wv %0d val %h"},
              want.jump, want.target, want.halted, want.flag, want.sp, want.wv, want.wval,
              got.jump, got.target, got.halted, got.flag, got.sp, got.wv, got.wval);
        end
      end
    end
  end

  function automatic instr_t mk(logic [4:0] c, logic [3:0] d, logic [3:0] a,
                                logic [3:0] b, logic [31:0] i);
    instr_t x;
    x.cmd = c; x.rd = d; x.ra = a; x.rb = b; x.imm = i;
    return x;
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'hffffffff;
      3: return $urandom_range(40);
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t rand_instr();
    instr_t x;
    x = instr_t'(49'({$urandom, $urandom}));
    if ($urandom_range(19) == 0) x.cmd = 5'($urandom_range(31, 21));
    else x.cmd = 5'($urandom_range(20, 1));
    if (x.cmd inside {rvmeu_pkg::CmdLoadi, rvmeu_pkg::CmdLoada, rvmeu_pkg::CmdLoadb,
                      rvmeu_pkg::CmdPushl}) x.imm = rand_val();
    if (x.cmd inside {rvmeu_pkg::CmdSinc, rvmeu_pkg::CmdSdec})
      x.imm = $signed($urandom_range(8)) - 4;
    if (x.cmd == rvmeu_pkg::CmdSinc && $urandom_range(9) == 0) x.imm = rand_val();
    return x;
  endfunction

  task automatic wait_drain();
    wait (pending_instrs.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_stack_top(logic [9:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    vm_sp = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(int n);
    repeat (n) pending_instrs.push_back(rand_instr());
    wait_drain();
  endtask

  initial begin
    #10000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    foreach (vm_regs[k]) vm_regs[k] = 0;
    foreach (vm_mem[k]) vm_mem[k] = 0;
    vm_sp = 0;
    vm_flag = 0;
    vm_stopped = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed
    pending_instrs.push_back(mk(rvmeu_pkg::CmdRcur, 0, 0, 0, 0));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdLoadi, 1, 0, 0, 32'h80000000));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdLoadi, 2, 0, 0, 32'hffffffff));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdLoadi, 15, 0, 0, 32'h7fffffff));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdDiv, 3, 1, 2, 0));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdDiv, 4, 15, 0, 0));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdMul, 5, 15, 15, 0));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdAdd, 6, 15, 15, 0));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdSub, 7, 1, 15, 0));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdLoada, 2, 0, 0, 32'h12345678));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdLoadb, 2, 0, 0, 32'habcd0123));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdPush, 15, 0, 0, 0));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdPushl, 0, 0, 0, 32'hffffffff));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdPop, 8, 0, 0, 0));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdPop, 9, 0, 0, 0));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdMemw, 15, 2, 0, 0));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdMemr, 10, 1, 0, 0));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdMemr, 11, 2, 0, 0));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdCmp, 8, 15, 0, 0));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdJmpeq, 0, 0, 0, 32'hdeadbeef));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdCmp, 0, 0, 0, 0));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdJmpeq, 0, 0, 0, 32'h80000000));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdJmp, 0, 0, 0, 32'h7fffffff));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdSinc, 0, 0, 0, 32'h80000000));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdSdec, 0, 0, 0, 32'hfffffffd));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdWcur, 15, 0, 0, 0));
    pending_instrs.push_back(mk(rvmeu_pkg::CmdNop, 0, 0, 0, 0));
    pending_instrs.push_back(mk(5'd31, 0, 0, 0, 0));
    wait_drain();

    send_idle_pct = 24; recv_idle_pct = 46;
    write_stack_top(10'h3ff);
    run_random(230);
    send_idle_pct = 46; recv_idle_pct = 24;
    write_stack_top(10'h000);
    run_random(230);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_stack_top(10'($urandom));
    write_stack_top(10'h155);
    run_random(220);
    // halt then ignored instructions
    pending_instrs.push_back(mk(rvmeu_pkg::CmdHalt, 0, 0, 0, 0));
    repeat (20) pending_instrs.push_back(rand_instr());
    wait_drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
